@@ rtl/dsit_pkg.sv @@
// Package for the depth sorted insert table: payload structs, op codes,
// register indexes, sizes and the back end state type. No dependencies.
`default_nettype none
package dsit_pkg;
  localparam int CAPACITY = 1024;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int DW = 52;
  localparam int TW = 11;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [13:0] TIE_BASE = 14'd10000;
  localparam logic [13:0] TIE_LOW  = 14'd9999;
  localparam logic [13:0] TIE_HIGH = 14'd10001;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        item_handle;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        owner_id;
    logic [7:0]         sort_rank;
    logic               runner_flag;
    logic [9:0]         read_position;
  } in_word_t;

  typedef struct packed {
    logic [15:0]   out_handle;
    logic [DW-1:0] out_distance;
    logic [TW-1:0] entry_total;
    logic [1:0]    status;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    func_t         func;
    logic [15:0]   handle;
    logic [DW-1:0] sq_dist;
    logic [65:0]   lo;
    logic [65:0]   hi;
    logic [15:0]   owner;
    logic [7:0]    rank;
    logic          runner;
    logic [9:0]    rpos;
  } cmd_t;

  typedef struct packed {
    logic [DW-1:0] sq_dist;
    logic [15:0]   handle;
    logic [15:0]   owner;
    logic [7:0]    rank;
    logic          runner;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_RREAD, BK_FETCH, BK_CMP, BK_WRITE, BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

@@ rtl/dsit_front.sv @@
// Front end: accepts input words, computes squared distance and tie bounds.
// Depends on dsit_pkg. Three register stages, one word per cycle while cmd_ready does not stall them.
`default_nettype none
module dsit_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic signed [23:0] cam_x,
  input  wire logic signed [23:0] cam_y,
  input  wire logic signed [23:0] cam_z,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dsit_pkg::in_word_t in_data,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output dsit_pkg::cmd_t         cmd_data
);
  import dsit_pkg::*;

  logic        v1, v2, v3;
  in_word_t    w1, w2, w3;
  logic [24:0] ax, ay, az;
  logic [49:0] sx, sy, sz;
  logic [DW-1:0] d3;
  logic [65:0] lo3, hi3;
  logic        adv;
  logic signed [24:0] dx, dy, dz;

  assign adv = !v3 || cmd_ready;
  assign in_ready = adv;

  always_comb begin
    dx = 25'(in_data.pos_x) - 25'(cam_x);
    dy = 25'(in_data.pos_y) - 25'(cam_y);
    dz = 25'(in_data.pos_z) - 25'(cam_z);
  end

  // stage pipeline: abs diff, square, sum and tie bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      w1 <= in_data;
      ax <= dx[24] ? 25'(-dx) : 25'(dx);
      ay <= dy[24] ? 25'(-dy) : 25'(dy);
      az <= dz[24] ? 25'(-dz) : 25'(dz);
      w2 <= w1;
      sx <= 50'(ax) * 50'(ax);
      sy <= 50'(ay) * 50'(ay);
      sz <= 50'(az) * 50'(az);
      w3 <= w2;
      d3 <= DW'(sx) + DW'(sy) + DW'(sz);
      lo3 <= 66'(DW'(sx) + DW'(sy) + DW'(sz)) * 66'(TIE_LOW);
      hi3 <= 66'(DW'(sx) + DW'(sy) + DW'(sz)) * 66'(TIE_HIGH);
    end
  end

  assign cmd_valid = v3;
  always_comb begin
    cmd_data.func    = func_t'(w3.func);
    cmd_data.handle  = w3.item_handle;
    cmd_data.sq_dist = d3;
    cmd_data.lo      = lo3;
    cmd_data.hi      = hi3;
    cmd_data.owner   = w3.owner_id;
    cmd_data.rank    = w3.sort_rank;
    cmd_data.runner  = w3.runner_flag;
    cmd_data.rpos    = w3.read_position;
  end
endmodule
`default_nettype wire

@@ rtl/dsit_queue.sv @@
// Short queue between front and back ends (two entries).
// Depends on dsit_pkg for the command type.
`default_nettype none
module dsit_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire dsit_pkg::cmd_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output dsit_pkg::cmd_t      rd_data
);
  import dsit_pkg::*;

  cmd_t       slots [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = slots[rp];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) slots[wp] <= wr_data;
  end
endmodule
`default_nettype wire

@@ rtl/dsit_back.sv @@
// Back end: sorted table memory and the tail-first insertion walk.
// Depends on dsit_pkg. At most one memory read and one write per cycle.
`default_nettype none
module dsit_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire dsit_pkg::cmd_t cmd_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dsit_pkg::out_word_t out_data
);
  import dsit_pkg::*;

  entry_t    mem [CAPACITY];
  entry_t    rd_q;
  logic [AW-1:0] rd_addr;
  logic      rd_en;
  logic [AW-1:0] wr_addr;
  entry_t    wr_data;
  logic      wr_en;

  bk_state_t state, state_next;
  cmd_t      cmd, cmd_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] j, j_next;
  out_word_t res, res_next;
  logic [65:0] s;
  logic      move;

  // registered-read memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign s = 66'(rd_q.sq_dist) * 66'(TIE_BASE);
  always_comb begin
    if (s < cmd.lo) move = 1'b1;
    else if (s >= cmd.hi) move = 1'b0;
    else move = rd_q.owner == cmd.owner && !(cmd.runner && rd_q.runner) &&
                cmd.rank < rd_q.rank;
  end

  assign cmd_ready = state == BK_IDLE;
  assign out_valid = state == BK_OUT;
  assign out_data = res;

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    count_next = count;
    j_next = j;
    res_next = res;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = j[AW-1:0];
    wr_data = rd_q;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_next = cmd_data;
          res_next = '{out_handle: 16'd0, out_distance: '0,
                       entry_total: TW'(count), status: ST_OK};
          case (cmd_data.func)
            FUNC_CLEAR: begin
              count_next = '0;
              res_next.entry_total = '0;
              state_next = BK_OUT;
            end
            FUNC_READ: begin
              if (CW'(cmd_data.rpos) >= count) begin
                res_next.status = ST_RANGE;
                state_next = BK_OUT;
              end else begin
                rd_en = 1'b1;
                rd_addr = AW'(cmd_data.rpos);
                state_next = BK_RREAD;
              end
            end
            FUNC_INSERT: begin
              res_next.out_handle = cmd_data.handle;
              res_next.out_distance = cmd_data.sq_dist;
              if (count >= CW'(CAPACITY)) begin
                res_next.status = ST_FULL;
                state_next = BK_OUT;
              end else begin
                j_next = count;
                state_next = (count == '0) ? BK_WRITE : BK_FETCH;
              end
            end
            default: state_next = BK_OUT;
          endcase
        end
      end
      BK_RREAD: begin
        res_next.out_handle = rd_q.handle;
        res_next.out_distance = rd_q.sq_dist;
        state_next = BK_OUT;
      end
      BK_FETCH: begin
        rd_en = 1'b1;
        rd_addr = AW'(j - 1'b1);
        state_next = BK_CMP;
      end
      BK_CMP: begin
        // shift the nearer entry up one place, else stop at the hole
        if (move) begin
          wr_en = 1'b1;
          j_next = j - 1'b1;
          state_next = (j == CW'(1)) ? BK_WRITE : BK_FETCH;
        end else begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: begin
        wr_en = 1'b1;
        wr_data = '{sq_dist: cmd.sq_dist, handle: cmd.handle, owner: cmd.owner,
                    rank: cmd.rank, runner: cmd.runner};
        count_next = count + 1'b1;
        res_next.entry_total = TW'(count + 1'b1);
        state_next = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cmd <= cmd_next;
    j <= j_next;
    res <= res_next;
  end
endmodule
`default_nettype wire

@@ rtl/depth_sorted_insert_table_unit.sv @@
// Depth sorted insert table, top level: config registers, front, queue, back.
// The back end takes one word at a time and goes back to idle only once its
// result is taken; a read fetches one entry and an insert walks from the tail,
// one compare per entry it passes. Clear, refused insert and read beyond count
// answer without a walk. The front and queue overlap with the back end.
// Reset (rst, synchronous) zeroes the count and camera; no clearing pass.
`default_nettype none
module depth_sorted_insert_table_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [23:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dsit_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dsit_pkg::out_word_t      out_data
);
  import dsit_pkg::*;

  logic signed [23:0] cam_x, cam_y, cam_z;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_data, qb_data;

  // hold camera registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0; cam_y <= '0; cam_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAM_X: cam_x <= cfg_data;
        REG_CAM_Y: cam_y <= cfg_data;
        REG_CAM_Z: cam_z <= cfg_data;
        default: ;
      endcase
    end
  end

  dsit_front u_front (.clk, .rst, .cam_x, .cam_y, .cam_z, .in_valid, .in_ready,
    .in_data, .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd_data(fq_data));
  dsit_queue u_queue (.clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_data(fq_data), .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));
  dsit_back u_back (.clk, .rst, .cmd_valid(qb_valid), .cmd_ready(qb_ready),
    .cmd_data(qb_data), .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire
